// ===== rtl/core/dhsl_pkg.sv =====
`default_nettype none
package dhsl_pkg;

  // field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WIDE_W    = 64;
  localparam int unsigned FLEN_W    = 40;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // header geometry
  localparam int unsigned HDR_BYTES = 32;
  localparam int unsigned HDR_W     = HDR_BYTES * BYTE_W;
  localparam int unsigned CNT_W     = $clog2(HDR_BYTES);
  localparam int unsigned STEP_W    = 3;

  // stream widths
  localparam int unsigned S_TDATA_W = BYTE_W + 3 * WORD_W;
  localparam int unsigned M_FIELD_W = 2 * WIDE_W + 2 * WORD_W + 1;
  localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W   = M_TDATA_W - M_FIELD_W;

  // op codes
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BYTE    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_CORRUPT = 3'd2;
  localparam logic [STAT_W-1:0] STAT_OOB     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_WP      = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOHDR   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_PROT  = 2'd1;

  // drive type codes for the standard geometries
  localparam logic [WORD_W-1:0] TYPE_1440  = 32'h30;
  localparam logic [WORD_W-1:0] TYPE_1200  = 32'h90;
  localparam logic [WORD_W-1:0] TYPE_OTHER = 32'h10;
  localparam logic [WORD_W-1:0] STD_CYL    = 32'd80;
  localparam logic [WORD_W-1:0] STD_HEADS  = 32'd2;
  localparam logic [WORD_W-1:0] STD_BPS    = 32'd512;
  localparam logic [WORD_W-1:0] SPT_1440   = 32'd18;
  localparam logic [WORD_W-1:0] SPT_1200   = 32'd15;

  typedef enum logic [2:0] {
    RES_BYTE, RES_NOHDR, RES_WP, RES_OOB, RES_HDR, RES_REQ
  } res_kind_t;

  typedef enum logic [1:0] {A_TRACK, A_ACC_LO, A_ACC_HI, A_HDR_BPS} mul_a_t;

  typedef enum logic [2:0] {
    B_HC, B_SPT, B_BPS, B_HDR_SPT, B_HDR_HD, B_HDR_CYL
  } mul_b_t;

  typedef enum logic [1:0] {ACC_KEEP, ACC_PROD, ACC_HI} acc_op_t;

  typedef enum logic [1:0] {ADD_ZERO, ADD_HEAD, ADD_SM1, ADD_HLEN} add_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      shift_byte;
    logic      latch_req;
    logic      mul_en;
    mul_a_t    a_sel;
    mul_b_t    b_sel;
    acc_op_t   acc_op;
    add_sel_t  add_sel;
    logic      lba_load;
    logic      out_load;
    res_kind_t kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic geo_valid;
    logic write_prot;
    logic in_bounds;
  } stat_t;

  // usual drive type code for a geometry
  function automatic logic [WORD_W-1:0] usual_type(
    input logic [WORD_W-1:0] cyl,
    input logic [WORD_W-1:0] hd,
    input logic [WORD_W-1:0] spt,
    input logic [WORD_W-1:0] bps
  );
    logic [WORD_W-1:0] code;
    code = TYPE_OTHER;
    if (cyl == STD_CYL && hd == STD_HEADS && bps == STD_BPS) begin
      if (spt == SPT_1440) begin
        code = TYPE_1440;
      end else if (spt == SPT_1200) begin
        code = TYPE_1200;
      end
    end
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dhsl_dp.sv =====
`default_nettype none
module dhsl_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [dhsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dhsl_pkg::FLEN_W-1:0]        cfg_data,
  input  wire logic [dhsl_pkg::BYTE_W-1:0]        in_byte,
  input  wire logic [dhsl_pkg::WORD_W-1:0]        in_track,
  input  wire logic [dhsl_pkg::WORD_W-1:0]        in_head,
  input  wire logic [dhsl_pkg::WORD_W-1:0]        in_sector,
  input  wire dhsl_pkg::cmd_t                     cmd,
  output dhsl_pkg::stat_t                         stat,
  output logic [dhsl_pkg::STAT_W-1:0]             o_status,
  output logic [dhsl_pkg::WIDE_W-1:0]             o_offset,
  output logic [dhsl_pkg::WIDE_W-1:0]             o_block,
  output logic [dhsl_pkg::WORD_W-1:0]             o_dlen,
  output logic [dhsl_pkg::WORD_W-1:0]             o_type,
  output logic                                    o_match
);

  localparam int unsigned WW = dhsl_pkg::WORD_W;
  localparam int unsigned XW = dhsl_pkg::WIDE_W;

  // header word positions
  localparam int unsigned HW_RSV  = 0;
  localparam int unsigned HW_TYPE = 1;
  localparam int unsigned HW_HLEN = 2;
  localparam int unsigned HW_DSZ  = 3;
  localparam int unsigned HW_BPS  = 4;
  localparam int unsigned HW_SPT  = 5;
  localparam int unsigned HW_HD   = 6;
  localparam int unsigned HW_CYL  = 7;
  localparam logic [WW-1:0] MIN_HLEN = WW'(dhsl_pkg::HDR_BYTES);

  logic [dhsl_pkg::HDR_W-1:0]  hdr;
  logic [dhsl_pkg::FLEN_W-1:0] file_length;
  logic                        write_prot;
  logic                        geo_valid;
  logic [WW-1:0] g_hlen, g_bps, g_spt, g_hc, g_cyl;
  logic [WW-1:0] r_track, r_head, r_sm1;
  logic [XW-1:0] prod, acc, lba;

  logic [WW-1:0] w_rsv, w_type, w_hlen, w_dsz, w_bps, w_spt, w_hd, w_cyl;
  logic [WW-1:0] opa, opb, addend;
  logic [WW:0]   hsum;
  logic [XW-1:0] end_sum;
  logic          hdr_ok, past_end;

  logic [dhsl_pkg::STAT_W-1:0] status_next;
  logic [XW-1:0]               offset_next, block_next;
  logic [WW-1:0]               dlen_next, type_next;
  logic                        match_next;

  // header words, little-endian, first byte lowest
  assign w_rsv  = hdr[WW*HW_RSV  +: WW];
  assign w_type = hdr[WW*HW_TYPE +: WW];
  assign w_hlen = hdr[WW*HW_HLEN +: WW];
  assign w_dsz  = hdr[WW*HW_DSZ  +: WW];
  assign w_bps  = hdr[WW*HW_BPS  +: WW];
  assign w_spt  = hdr[WW*HW_SPT  +: WW];
  assign w_hd   = hdr[WW*HW_HD   +: WW];
  assign w_cyl  = hdr[WW*HW_CYL  +: WW];

  // status toward the controller
  assign stat.geo_valid  = geo_valid;
  assign stat.write_prot = write_prot;
  assign stat.in_bounds  = (in_track < g_cyl) && (in_head < g_hc) &&
                           (in_sector != '0) && (in_sector <= g_spt);

  // multiplier operand select
  always_comb begin
    unique case (cmd.a_sel)
      dhsl_pkg::A_TRACK:   opa = r_track;
      dhsl_pkg::A_ACC_LO:  opa = acc[WW-1:0];
      dhsl_pkg::A_ACC_HI:  opa = acc[XW-1:WW];
      dhsl_pkg::A_HDR_BPS: opa = w_bps;
    endcase
  end

  always_comb begin
    unique case (cmd.b_sel)
      dhsl_pkg::B_HC:      opb = g_hc;
      dhsl_pkg::B_SPT:     opb = g_spt;
      dhsl_pkg::B_BPS:     opb = g_bps;
      dhsl_pkg::B_HDR_SPT: opb = w_spt;
      dhsl_pkg::B_HDR_HD:  opb = w_hd;
      dhsl_pkg::B_HDR_CYL: opb = w_cyl;
      default:             opb = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.add_sel)
      dhsl_pkg::ADD_ZERO: addend = '0;
      dhsl_pkg::ADD_HEAD: addend = r_head;
      dhsl_pkg::ADD_SM1:  addend = r_sm1;
      dhsl_pkg::ADD_HLEN: addend = g_hlen;
    endcase
  end

  // header check; acc holds the geometry product here
  assign hsum   = {1'b0, w_hlen} + {1'b0, acc[WW-1:0]};
  assign hdr_ok = (w_rsv == '0) && (w_hlen >= MIN_HLEN) &&
                  (w_bps != '0) && (w_spt != '0) && (w_hd != '0) && (w_cyl != '0) &&
                  ((w_dsz == '0) || ({{(XW-WW){1'b0}}, w_dsz} == acc)) &&
                  ({{(dhsl_pkg::FLEN_W-WW-1){1'b0}}, hsum} <= file_length);

  // sector end past end of file; acc holds the byte offset here
  assign end_sum  = acc + {{(XW-WW){1'b0}}, g_bps};
  assign past_end = end_sum > {{(XW-dhsl_pkg::FLEN_W){1'b0}}, file_length};

  // result formation
  always_comb begin
    status_next = dhsl_pkg::STAT_CORRUPT;
    offset_next = '0;
    block_next  = '0;
    dlen_next   = '0;
    type_next   = '0;
    match_next  = 1'b0;
    unique case (cmd.kind)
      dhsl_pkg::RES_BYTE:  status_next = dhsl_pkg::STAT_BYTE;
      dhsl_pkg::RES_NOHDR: status_next = dhsl_pkg::STAT_NOHDR;
      dhsl_pkg::RES_WP:    status_next = dhsl_pkg::STAT_WP;
      dhsl_pkg::RES_OOB:   status_next = dhsl_pkg::STAT_OOB;
      dhsl_pkg::RES_HDR: begin
        if (hdr_ok) begin
          status_next = dhsl_pkg::STAT_OK;
          dlen_next   = acc[WW-1:0];
          type_next   = w_type;
          match_next  = (dhsl_pkg::usual_type(w_cyl, w_hd, w_spt, w_bps) == w_type);
        end
      end
      dhsl_pkg::RES_REQ: begin
        status_next = past_end ? dhsl_pkg::STAT_CORRUPT : dhsl_pkg::STAT_OK;
        offset_next = acc;
        block_next  = lba;
      end
      default: status_next = dhsl_pkg::STAT_CORRUPT;
    endcase
  end

  // control-relevant registers
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
      write_prot  <= 1'b0;
      geo_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == dhsl_pkg::CFG_FILE_LEN) begin
          file_length <= cfg_data;
        end else if (cfg_index == dhsl_pkg::CFG_WR_PROT) begin
          write_prot <= cfg_data[0];
        end
      end
      if (cmd.out_load && cmd.kind == dhsl_pkg::RES_HDR) begin
        geo_valid <= hdr_ok;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      hdr <= {in_byte, hdr[dhsl_pkg::HDR_W-1:dhsl_pkg::BYTE_W]};
    end
    if (cmd.latch_req) begin
      r_track <= in_track;
      r_head  <= in_head;
      r_sm1   <= in_sector - WW'(1);
    end
    // one 32x32 multiply per cycle while mul_en is set
    if (cmd.mul_en) begin
      prod <= XW'(opa) * XW'(opb);
    end
    // accumulate low product or fold in high partial product
    unique case (cmd.acc_op)
      dhsl_pkg::ACC_KEEP: acc <= acc;
      dhsl_pkg::ACC_PROD: acc <= prod + {{(XW-WW){1'b0}}, addend};
      dhsl_pkg::ACC_HI:   acc <= acc + {prod[WW-1:0], addend};
      default:            acc <= acc;
    endcase
    if (cmd.lba_load) begin
      lba <= acc;
    end
    // geometry is taken only from a header that passed
    if (cmd.out_load && cmd.kind == dhsl_pkg::RES_HDR && hdr_ok) begin
      g_hlen <= w_hlen;
      g_bps  <= w_bps;
      g_spt  <= w_spt;
      g_hc   <= w_hd;
      g_cyl  <= w_cyl;
    end
    if (cmd.out_load) begin
      o_status <= status_next;
      o_offset <= offset_next;
      o_block  <= block_next;
      o_dlen   <= dlen_next;
      o_type   <= type_next;
      o_match  <= match_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dhsl_ctrl.sv =====
`default_nettype none
module dhsl_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_valid,
  output logic                             s_ready,
  input  wire logic [dhsl_pkg::OP_W-1:0]   s_op,
  output logic                             m_valid,
  input  wire logic                        m_ready,
  output dhsl_pkg::cmd_t                   cmd,
  input  wire dhsl_pkg::stat_t             stat
);

  typedef enum logic [1:0] {ST_IDLE, ST_REQ, ST_HDR, ST_FIN} state_t;

  localparam logic [dhsl_pkg::CNT_W-1:0]  CNT_LAST  = dhsl_pkg::CNT_W'(dhsl_pkg::HDR_BYTES - 1);
  localparam logic [dhsl_pkg::STEP_W-1:0] STEP_LAST = {dhsl_pkg::STEP_W{1'b1}};

  state_t                         state;
  logic [dhsl_pkg::STEP_W-1:0]    step;
  logic [dhsl_pkg::CNT_W-1:0]     byte_count;
  dhsl_pkg::res_kind_t            kind;
  logic                           s_fire, out_free, is_req;

  assign s_ready  = (state == ST_IDLE);
  assign s_fire   = s_valid && s_ready;
  assign out_free = !m_valid || m_ready;
  assign is_req   = (s_op == dhsl_pkg::OP_READ) || (s_op == dhsl_pkg::OP_WRITE);

  // command decode from state and step
  always_comb begin
    cmd            = '0;
    cmd.shift_byte = s_fire && (s_op == dhsl_pkg::OP_BYTE);
    cmd.latch_req  = s_fire && is_req;
    cmd.kind       = kind;
    cmd.out_load   = (state == ST_FIN) && out_free;
    unique case (state)
      // lba = ((t*hc + h)*spt) + s-1, then offset = hlen + lba*bps
      ST_REQ: begin
        unique case (step)
          3'd0: begin
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_TRACK; cmd.b_sel = dhsl_pkg::B_HC;
          end
          3'd1: begin
            cmd.acc_op = dhsl_pkg::ACC_PROD; cmd.add_sel = dhsl_pkg::ADD_HEAD;
          end
          3'd2: begin
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_ACC_LO; cmd.b_sel = dhsl_pkg::B_SPT;
          end
          3'd3: begin
            cmd.acc_op = dhsl_pkg::ACC_PROD; cmd.add_sel = dhsl_pkg::ADD_ZERO;
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_ACC_HI; cmd.b_sel = dhsl_pkg::B_SPT;
          end
          3'd4: begin
            cmd.acc_op = dhsl_pkg::ACC_HI; cmd.add_sel = dhsl_pkg::ADD_SM1;
          end
          3'd5: begin
            cmd.lba_load = 1'b1;
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_ACC_LO; cmd.b_sel = dhsl_pkg::B_BPS;
          end
          3'd6: begin
            cmd.acc_op = dhsl_pkg::ACC_PROD; cmd.add_sel = dhsl_pkg::ADD_HLEN;
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_ACC_HI; cmd.b_sel = dhsl_pkg::B_BPS;
          end
          3'd7: begin
            cmd.acc_op = dhsl_pkg::ACC_HI; cmd.add_sel = dhsl_pkg::ADD_ZERO;
          end
        endcase
      end
      // product = bps*spt*heads*cylinders, modulo 2^64
      ST_HDR: begin
        unique case (step)
          3'd0: begin
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_HDR_BPS;
            cmd.b_sel = dhsl_pkg::B_HDR_SPT;
          end
          3'd1: begin
            cmd.acc_op = dhsl_pkg::ACC_PROD; cmd.add_sel = dhsl_pkg::ADD_ZERO;
          end
          3'd2: begin
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_ACC_LO; cmd.b_sel = dhsl_pkg::B_HDR_HD;
          end
          3'd3: begin
            cmd.acc_op = dhsl_pkg::ACC_PROD; cmd.add_sel = dhsl_pkg::ADD_ZERO;
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_ACC_HI; cmd.b_sel = dhsl_pkg::B_HDR_HD;
          end
          3'd4: begin
            cmd.acc_op = dhsl_pkg::ACC_HI; cmd.add_sel = dhsl_pkg::ADD_ZERO;
          end
          3'd5: begin
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_ACC_LO;
            cmd.b_sel = dhsl_pkg::B_HDR_CYL;
          end
          3'd6: begin
            cmd.acc_op = dhsl_pkg::ACC_PROD; cmd.add_sel = dhsl_pkg::ADD_ZERO;
            cmd.mul_en = 1'b1; cmd.a_sel = dhsl_pkg::A_ACC_HI;
            cmd.b_sel = dhsl_pkg::B_HDR_CYL;
          end
          3'd7: begin
            cmd.acc_op = dhsl_pkg::ACC_HI; cmd.add_sel = dhsl_pkg::ADD_ZERO;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      byte_count <= '0;
      kind       <= dhsl_pkg::RES_BYTE;
      m_valid    <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_op == dhsl_pkg::OP_BYTE) begin
              if (byte_count == CNT_LAST) begin
                byte_count <= '0;
                kind       <= dhsl_pkg::RES_HDR;
                state      <= ST_HDR;
              end else begin
                byte_count <= byte_count + dhsl_pkg::CNT_W'(1);
                kind       <= dhsl_pkg::RES_BYTE;
                state      <= ST_FIN;
              end
            end else if (is_req) begin
              // no header, then write protect, then bounds
              if (!stat.geo_valid) begin
                kind  <= dhsl_pkg::RES_NOHDR;
                state <= ST_FIN;
              end else if (s_op == dhsl_pkg::OP_WRITE && stat.write_prot) begin
                kind  <= dhsl_pkg::RES_WP;
                state <= ST_FIN;
              end else if (!stat.in_bounds) begin
                kind  <= dhsl_pkg::RES_OOB;
                state <= ST_FIN;
              end else begin
                kind  <= dhsl_pkg::RES_REQ;
                state <= ST_REQ;
              end
            end
          end
        end
        ST_REQ, ST_HDR: begin
          step <= step + dhsl_pkg::STEP_W'(1);
          if (step == STEP_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_valid <= 1'b1;
            state   <= ST_IDLE;
          end
        end
      endcase
    end
  end

  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_op == dhsl_pkg::OP_BYTE && byte_count != CNT_LAST |=>
      byte_count == dhsl_pkg::CNT_W'($past(byte_count) + dhsl_pkg::CNT_W'(1)))
    else $error("header byte count did not advance");

  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_op == dhsl_pkg::OP_BYTE && byte_count == CNT_LAST |=>
      state == ST_HDR && step == '0 && byte_count == '0)
    else $error("last header byte did not start the header check");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> step == '0)
    else $error("sequence step not cleared in idle");

  a_nohdr: assert property (@(posedge clk) disable iff (rst)
    s_fire && is_req && !stat.geo_valid |=>
      state == ST_FIN && kind == dhsl_pkg::RES_NOHDR)
    else $error("request without geometry not rejected");

endmodule
`default_nettype wire

// ===== rtl/core/disk_image_header_and_sector_locator.sv =====
// Disk image header checker and sector locator.
// Input stream (s_axis): tuser carries the op (header byte, sector read,
// sector write); tdata carries header_byte, track, head and sector. Header
// bytes are taken in file order; the 32nd byte triggers the header check.
// Output stream (m_axis): one result per item; tuser is the status, tdata
// holds byte_offset, block_number, data_length, stored_type, type_matches.
// Config channel: cfg_index 0 writes the file length, 1 the write protect;
// other indexes are ignored. Write only while no item is in flight.
// A header byte or a rejected request goes straight to the final step,
// where its result enters the output register; the last header byte and
// a checked request first take eight steps through one shared 32x32
// multiplier and accumulator. One item is in work at a time; op code 3 is
// consumed with no result. A finished result sits in the output register,
// and the next item is accepted while it waits; that item stalls in its
// final step until the output register is free.
// Reset clears the byte count, the header-valid flag and both config
// registers; requests before a good header report no valid header.
`default_nettype none
module disk_image_header_and_sector_locator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: header_byte[7:0], track[39:8], head[71:40], sector[103:72]
  input  wire logic [dhsl_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // tuser: op[1:0]
  input  wire logic [dhsl_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: byte_offset[63:0], block_number[127:64], data_length[159:128],
  //        stored_type[191:160], type_matches[192], zero pad above
  output logic [dhsl_pkg::M_TDATA_W-1:0]           m_axis_tdata,
  // tuser: status[2:0]
  output logic [dhsl_pkg::STAT_W-1:0]              m_axis_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dhsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dhsl_pkg::FLEN_W-1:0]         cfg_data
);

  localparam int unsigned BW = dhsl_pkg::BYTE_W;
  localparam int unsigned WW = dhsl_pkg::WORD_W;

  dhsl_pkg::cmd_t  cmd;
  dhsl_pkg::stat_t stat;

  logic [dhsl_pkg::WIDE_W-1:0] o_offset, o_block;
  logic [WW-1:0]               o_dlen, o_type;
  logic                        o_match;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  dhsl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_op    (s_axis_tuser),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd),
    .stat    (stat)
  );

  dhsl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_axis_tdata[BW-1:0]),
    .in_track  (s_axis_tdata[BW +: WW]),
    .in_head   (s_axis_tdata[BW + WW +: WW]),
    .in_sector (s_axis_tdata[BW + 2*WW +: WW]),
    .cmd       (cmd),
    .stat      (stat),
    .o_status  (m_axis_tuser),
    .o_offset  (o_offset),
    .o_block   (o_block),
    .o_dlen    (o_dlen),
    .o_type    (o_type),
    .o_match   (o_match)
  );

  // result packing, first field lowest
  assign m_axis_tdata = {{dhsl_pkg::M_PAD_W{1'b0}}, o_match, o_type, o_dlen,
                         o_block, o_offset};

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import dhsl_pkg::*;

  // codes the package leaves out: the unused op and a register index that is ignored
  localparam logic [OP_W-1:0]      OP_NONE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  // one result of the locator, unpacked from tuser and tdata
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WIDE_W-1:0] byte_offset;
    logic [WIDE_W-1:0] block_number;
    logic [WORD_W-1:0] data_length;
    logic [WORD_W-1:0] stored_type;
    logic              type_matches;
  } locate_t;

  typedef enum logic [1:0] {ROW_REG, ROW_ITEM, ROW_HEADER} row_kind_t;

  // one line of the directed plan
  typedef struct {
    row_kind_t            kind;
    logic [OP_W-1:0]      op;
    logic [WORD_W-1:0]    trk;
    logic [WORD_W-1:0]    hd;
    logic [WORD_W-1:0]    sec;
    logic [HDR_W-1:0]     image;
    logic [CFG_IDX_W-1:0] idx;
    logic [FLEN_W-1:0]    value;
    bit                   typed;
    logic [STAT_W-1:0]    stat;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FLEN_W-1:0]    cfg_data = '0;

  // locator state as predicted
  logic [BYTE_W-1:0] hdr_img [HDR_BYTES];
  logic [CNT_W-1:0]  hdr_pos = '0;
  logic              geo_ok = 1'b0;
  logic [WORD_W-1:0] p_hlen = '0;
  logic [WORD_W-1:0] p_bps = '0;
  logic [WORD_W-1:0] p_spt = '0;
  logic [WORD_W-1:0] p_heads = '0;
  logic [WORD_W-1:0] p_cyls = '0;
  logic [FLEN_W-1:0] p_flen = '0;
  logic              p_wprot = 1'b0;

  locate_t due_locations[$];

  int  fail_count = 0;
  int  n_bytes = 0;
  int  n_requests = 0;
  int  n_noise = 0;
  int  n_regs = 0;
  int  n_checked = 0;
  int  n_good_hdr = 0;
  int  n_bad_hdr = 0;
  int  n_past_end = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  bit  hold_request = 1'b0;

  always #1 clk = ~clk;

  disk_image_header_and_sector_locator u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Header collection and sector lookup; returns 0 when the item gives no result
  function automatic bit predict_location(
    input  logic [OP_W-1:0]   op,
    input  logic [BYTE_W-1:0] hb,
    input  logic [WORD_W-1:0] trk,
    input  logic [WORD_W-1:0] hd,
    input  logic [WORD_W-1:0] sec,
    output locate_t           r
  );
    logic [WORD_W-1:0] w [8];
    logic [WORD_W-1:0] code;
    logic [WIDE_W-1:0] prod;
    logic [WIDE_W-1:0] lba;
    logic [WIDE_W-1:0] off;
    bit                bad;
    r = '0;
    if (op == OP_NONE) begin
      return 1'b0;
    end
    if (op == OP_BYTE) begin
      n_bytes++;
      hdr_img[hdr_pos] = hb;
      if (hdr_pos != CNT_W'(HDR_BYTES - 1)) begin
        hdr_pos = hdr_pos + 1'b1;
        r.status = STAT_BYTE;
        return 1'b1;
      end
      hdr_pos = '0;
      // words: reserved, type, hlen, data size, bps, spt, heads, cylinders
      for (int i = 0; i < 8; i++) begin
        w[i] = {hdr_img[4*i+3], hdr_img[4*i+2], hdr_img[4*i+1], hdr_img[4*i]};
      end
      prod = 64'(w[4]) * 64'(w[5]) * 64'(w[6]) * 64'(w[7]);
      bad = (w[0] != '0) || (w[2] < HDR_BYTES) ||
            (w[4] == '0) || (w[5] == '0) || (w[6] == '0) || (w[7] == '0) ||
            (w[3] != '0 && 64'(w[3]) != prod) ||
            (64'(p_flen) < 64'(w[2]) + 64'(prod[WORD_W-1:0]));
      geo_ok = 1'b0;
      if (bad) begin
        n_bad_hdr++;
        r.status = STAT_CORRUPT;
        return 1'b1;
      end
      n_good_hdr++;
      geo_ok  = 1'b1;
      p_hlen  = w[2];
      p_bps   = w[4];
      p_spt   = w[5];
      p_heads = w[6];
      p_cyls  = w[7];
      code = TYPE_OTHER;
      if (w[7] == STD_CYL && w[6] == STD_HEADS && w[4] == STD_BPS) begin
        if (w[5] == SPT_1440) begin
          code = TYPE_1440;
        end else if (w[5] == SPT_1200) begin
          code = TYPE_1200;
        end
      end
      r.status       = STAT_OK;
      r.data_length  = prod[WORD_W-1:0];
      r.stored_type  = w[1];
      r.type_matches = (w[1] == code);
      return 1'b1;
    end
    // sector read or write
    n_requests++;
    if (!geo_ok) begin
      r.status = STAT_NOHDR;
    end else if (op == OP_WRITE && p_wprot) begin
      r.status = STAT_WP;
    end else if (trk >= p_cyls || hd >= p_heads || sec == '0 || sec > p_spt) begin
      r.status = STAT_OOB;
    end else begin
      lba = 64'(trk) * 64'(p_heads) * 64'(p_spt) + 64'(hd) * 64'(p_spt) +
            64'(sec - 32'd1);
      off = 64'(p_hlen) + lba * 64'(p_bps);
      r.byte_offset  = off;
      r.block_number = lba;
      if (off + 64'(p_bps) > 64'(p_flen)) begin
        r.status = STAT_CORRUPT;
        n_past_end++;
      end else begin
        r.status = STAT_OK;
      end
    end
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones, none in a burst stretch
  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 25);
  endfunction

  function automatic stim_row_t mk_reg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [FLEN_W-1:0] value);
    stim_row_t r;
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.value = value;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t mk_req(input logic [OP_W-1:0] op,
                                       input logic [WORD_W-1:0] trk,
                                       input logic [WORD_W-1:0] hd,
                                       input logic [WORD_W-1:0] sec,
                                       input bit typed,
                                       input logic [STAT_W-1:0] stat);
    stim_row_t r;
    r.kind  = ROW_ITEM;
    r.op    = op;
    r.trk   = trk;
    r.hd    = hd;
    r.sec   = sec;
    r.typed = typed;
    r.stat  = stat;
    return r;
  endfunction

  function automatic stim_row_t mk_hdr(input logic [WORD_W-1:0] rsv,
                                       input logic [WORD_W-1:0] typ,
                                       input logic [WORD_W-1:0] hlen,
                                       input logic [WORD_W-1:0] dsz,
                                       input logic [WORD_W-1:0] bps,
                                       input logic [WORD_W-1:0] spt,
                                       input logic [WORD_W-1:0] hds,
                                       input logic [WORD_W-1:0] cyl,
                                       input bit typed,
                                       input logic [STAT_W-1:0] stat);
    stim_row_t r;
    r.kind  = ROW_HEADER;
    r.image = {cyl, hds, spt, bps, dsz, hlen, typ, rsv};
    r.typed = typed;
    r.stat  = stat;
    return r;
  endfunction

  // Offer one item and record what it should produce once it is taken
  task automatic push_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] hb,
                           input logic [WORD_W-1:0] trk, input logic [WORD_W-1:0] hd,
                           input logic [WORD_W-1:0] sec, input bit typed,
                           input logic [STAT_W-1:0] stat);
    int      gap;
    locate_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {sec, hd, trk, hb};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (predict_location(op, hb, trk, hd, sec, r)) begin
      if (typed) begin
        r = '0;
        r.status = stat;
      end
      due_locations.push_back(r);
    end else begin
      n_noise++;
    end
  endtask

  // 32 header bytes; requests may be slipped in between bytes
  task automatic send_header(input logic [HDR_W-1:0] image, input bit byte_typed,
                             input bit last_typed, input logic [STAT_W-1:0] stat,
                             input bit mix);
    logic [OP_W-1:0] op;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (mix && $urandom_range(0, 7) == 0) begin
        op = ($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE;
        push_item(op, $urandom_range(0, 255), $urandom_range(0, 3), $urandom_range(0, 1),
                  $urandom_range(1, 20), 1'b0, STAT_OK);
      end
      if (i == HDR_BYTES - 1) begin
        push_item(OP_BYTE, image[8*i +: 8], $urandom, $urandom, $urandom, last_typed, stat);
      end else begin
        push_item(OP_BYTE, image[8*i +: 8], $urandom, $urandom, $urandom, byte_typed,
                  STAT_BYTE);
      end
    end
  endtask

  // stop offering, let every result drain, then let an ignored item clear
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (due_locations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FLEN_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_regs++;
    if (idx == CFG_FILE_LEN) begin
      p_flen = value;
    end else if (idx == CFG_WR_PROT) begin
      p_wprot = value[0];
    end
  endtask

  // One random image: file length, header (sometimes flawed), then requests
  task automatic run_episode(input int ep);
    logic [WORD_W-1:0] rsv, typ, hlen, dsz, bps, spt, hds, cyl;
    logic [WORD_W-1:0] trk, hd, sec;
    logic [WIDE_W-1:0] prod, need;
    logic [OP_W-1:0]   op;
    int                kind;
    int                nreq;
    no_idle = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 9);
    rsv = '0;
    case (kind)
      0: begin
        bps = STD_BPS; spt = SPT_1440; hds = STD_HEADS; cyl = STD_CYL;
      end
      1: begin
        bps = STD_BPS; spt = SPT_1200; hds = STD_HEADS; cyl = STD_CYL;
      end
      2: begin
        // full-range geometry: products wrap, offsets run past the file
        bps = $urandom; spt = $urandom; hds = $urandom; cyl = $urandom;
      end
      default: begin
        bps = ($urandom_range(0, 1) != 0) ? (32'd128 << $urandom_range(0, 4))
                                          : $urandom_range(1, 4096);
        spt = $urandom_range(1, 40);
        hds = $urandom_range(1, 8);
        cyl = $urandom_range(1, 90);
      end
    endcase
    prod = 64'(bps) * 64'(spt) * 64'(hds) * 64'(cyl);
    hlen = ($urandom_range(0, 7) == 0) ? $urandom : 32'(HDR_BYTES + $urandom_range(0, 512));
    dsz  = ($urandom_range(0, 1) != 0 && prod[63:32] == '0) ? prod[31:0] : '0;
    case ($urandom_range(0, 9))
      7: typ = $urandom;
      8: typ = TYPE_1440;
      9: typ = TYPE_1200;
      default: typ = (kind == 0) ? TYPE_1440 : (kind == 1) ? TYPE_1200 : TYPE_OTHER;
    endcase
    need = 64'(hlen) + 64'(prod[31:0]);

    // occasional flaw in an otherwise good header
    case ($urandom_range(0, 11))
      0: rsv = $urandom_range(1, 32'hFFFF_FFFF);
      1: hlen = $urandom_range(0, HDR_BYTES - 1);
      2: begin
        case ($urandom_range(0, 3))
          0: bps = '0;
          1: spt = '0;
          2: hds = '0;
          default: cyl = '0;
        endcase
      end
      3: dsz = prod[31:0] + $urandom_range(1, 1000);
      default: ;
    endcase

    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 9))
        0: write_reg(CFG_FILE_LEN, FLEN_W'({$urandom, $urandom}));
        1: write_reg(CFG_FILE_LEN, '1);
        2: write_reg(CFG_FILE_LEN, FLEN_W'(need - 64'd1));
        default: write_reg(CFG_FILE_LEN, FLEN_W'(need + $urandom_range(0, 4096)));
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_WR_PROT, FLEN_W'($urandom_range(0, 1)));
    end

    // a broken header earlier may have left the byte count mid-way
    while (hdr_pos != '0) begin
      push_item(OP_BYTE, $urandom_range(0, 255), $urandom, $urandom, $urandom, 1'b0,
                STAT_OK);
    end
    if (ep == 3 || ep == 25) begin
      hold_request = 1'b1;
    end
    send_header({cyl, hds, spt, bps, dsz, hlen, typ, rsv}, 1'b0, 1'b0, STAT_OK,
                $urandom_range(0, 4) == 0);

    nreq = $urandom_range(4, 20);
    for (int i = 0; i < nreq; i++) begin
      // shrinking the file under a good header pushes the last sectors out
      if (i == nreq / 2 && $urandom_range(0, 5) == 0) begin
        write_reg(CFG_FILE_LEN, FLEN_W'(need - 64'($urandom_range(1, 2048))));
      end
      if ($urandom_range(0, 9) == 0) begin
        op = OP_NONE;
      end else begin
        op = ($urandom_range(0, 2) == 0) ? OP_WRITE : OP_READ;
      end
      trk = $urandom_range(0, cyl - 1);
      hd  = $urandom_range(0, hds - 1);
      sec = $urandom_range(1, spt);
      case ($urandom_range(0, 14))
        0: trk = cyl;
        1: hd = hds;
        2: sec = '0;
        3: sec = spt + 1;
        4: begin
          trk = $urandom; hd = $urandom; sec = $urandom;
        end
        5: begin
          trk = cyl - 1; hd = hds - 1; sec = spt;
        end
        default: ;
      endcase
      push_item(op, $urandom_range(0, 255), trk, hd, sec, 1'b0, STAT_OK);
    end
  endtask

  // Result side: random back-pressure, long hold on request, field compare
  initial begin : result_sink
    int      stall_left;
    locate_t got;
    locate_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.status       = m_axis_tuser;
        got.byte_offset  = m_axis_tdata[63:0];
        got.block_number = m_axis_tdata[127:64];
        got.data_length  = m_axis_tdata[159:128];
        got.stored_type  = m_axis_tdata[191:160];
        got.type_matches = m_axis_tdata[192];
        if (due_locations.size() == 0) begin
          $error("unexpected result: status %0d offset %h", got.status, got.byte_offset);
          fail_count++;
        end else begin
          want = due_locations.pop_front();
          n_checked++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %h, got %h", want.byte_offset, got.byte_offset);
            fail_count++;
          end
          if (got.block_number !== want.block_number) begin
            $error("block_number: expected %h, got %h", want.block_number,
                   got.block_number);
            fail_count++;
          end
          if (got.data_length !== want.data_length) begin
            $error("data_length: expected %h, got %h", want.data_length, got.data_length);
            fail_count++;
          end
          if (got.stored_type !== want.stored_type) begin
            $error("stored_type: expected %h, got %h", want.stored_type, got.stored_type);
            fail_count++;
          end
          if (got.type_matches !== want.type_matches) begin
            $error("type_matches: expected %0d, got %0d", want.type_matches,
                   got.type_matches);
            fail_count++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("disk_image_header_and_sector_locator regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t plan[$];
    int        base;
    int        ep;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // before any header, with a zero file length
    plan.push_back(mk_req(OP_READ, 0, 0, 1, 1'b1, STAT_NOHDR));
    plan.push_back(mk_req(OP_WRITE, '1, '1, '1, 1'b1, STAT_NOHDR));
    plan.push_back(mk_req(OP_NONE, '1, '1, '1, 1'b0, STAT_OK));
    plan.push_back(mk_hdr(0, TYPE_1440, 32, 1474560, STD_BPS, SPT_1440, STD_HEADS, STD_CYL,
                          1'b1, STAT_CORRUPT));
    plan.push_back(mk_reg(CFG_FILE_LEN, '1));
    plan.push_back(mk_reg(CFG_SPARE, '0));
    // each header check failing on its own
    plan.push_back(mk_hdr('1, TYPE_1440, 32, 1474560, STD_BPS, SPT_1440, STD_HEADS, STD_CYL,
                          1'b1, STAT_CORRUPT));
    plan.push_back(mk_hdr(0, TYPE_1440, 31, 1474560, STD_BPS, SPT_1440, STD_HEADS, STD_CYL,
                          1'b1, STAT_CORRUPT));
    plan.push_back(mk_hdr(0, TYPE_1440, 32, 0, STD_BPS, 0, STD_HEADS, STD_CYL,
                          1'b1, STAT_CORRUPT));
    plan.push_back(mk_hdr(0, TYPE_1440, 32, 1474561, STD_BPS, SPT_1440, STD_HEADS, STD_CYL,
                          1'b1, STAT_CORRUPT));
    plan.push_back(mk_req(OP_READ, 0, 0, 1, 1'b1, STAT_NOHDR));
    // standard 1.44M image, then corners and bounds
    plan.push_back(mk_hdr(0, TYPE_1440, 32, 1474560, STD_BPS, SPT_1440, STD_HEADS, STD_CYL,
                          1'b0, STAT_OK));
    plan.push_back(mk_req(OP_READ, 0, 0, 1, 1'b0, STAT_OK));
    plan.push_back(mk_req(OP_READ, 79, 1, 18, 1'b0, STAT_OK));
    plan.push_back(mk_req(OP_READ, 0, 0, 0, 1'b1, STAT_OOB));
    plan.push_back(mk_req(OP_READ, 80, 0, 1, 1'b1, STAT_OOB));
    plan.push_back(mk_req(OP_WRITE, 0, 2, 1, 1'b1, STAT_OOB));
    plan.push_back(mk_req(OP_READ, 0, 0, 19, 1'b1, STAT_OOB));
    plan.push_back(mk_reg(CFG_WR_PROT, 1));
    plan.push_back(mk_req(OP_WRITE, 5, 1, 3, 1'b1, STAT_WP));
    plan.push_back(mk_req(OP_READ, 5, 1, 3, 1'b0, STAT_OK));
    plan.push_back(mk_reg(CFG_WR_PROT, 0));
    // file one byte short: the last sector falls past its end
    plan.push_back(mk_reg(CFG_FILE_LEN, 1474591));
    plan.push_back(mk_req(OP_READ, 79, 1, 18, 1'b0, STAT_OK));
    // replacement headers: 1.2M with and without the matching type code
    plan.push_back(mk_hdr(0, TYPE_1200, 32, 0, STD_BPS, SPT_1200, STD_HEADS, STD_CYL,
                          1'b0, STAT_OK));
    plan.push_back(mk_req(OP_WRITE, 79, 1, 15, 1'b0, STAT_OK));
    plan.push_back(mk_hdr(0, TYPE_1440, 32, 1228800, STD_BPS, SPT_1200, STD_HEADS, STD_CYL,
                          1'b0, STAT_OK));
    // all-ones geometry: every product wraps
    plan.push_back(mk_reg(CFG_FILE_LEN, '1));
    plan.push_back(mk_hdr(0, '1, '1, 0, '1, '1, '1, '1, 1'b0, STAT_OK));
    plan.push_back(mk_req(OP_READ, 32'hFFFF_FFFE, 32'hFFFF_FFFE, '1, 1'b0, STAT_OK));
    plan.push_back(mk_req(OP_WRITE, 0, 0, '1, 1'b0, STAT_OK));

    foreach (plan[k]) begin
      case (plan[k].kind)
        ROW_REG: write_reg(plan[k].idx, plan[k].value);
        ROW_HEADER: send_header(plan[k].image, 1'b1, plan[k].typed, plan[k].stat, 1'b0);
        default: push_item(plan[k].op, $urandom_range(0, 255), plan[k].trk, plan[k].hd,
                           plan[k].sec, plan[k].typed, plan[k].stat);
      endcase
    end

    base = n_bytes + n_requests;
    ep = 0;
    while (n_bytes + n_requests - base < RANDOM_ITEMS) begin
      run_episode(ep);
      ep++;
    end
    no_idle = 1'b0;
    wait_idle();

    $display("Covered %0d header bytes, %0d sector requests, %0d ignored items, %0d reg writes",
             n_bytes, n_requests, n_noise, n_regs);
    $display("Checked %0d results: %0d headers accepted, %0d rejected, %0d sectors past EOF",
             n_checked, n_good_hdr, n_bad_hdr, n_past_end);
    if (fail_count == 0) begin
      $display("disk_image_header_and_sector_locator regression: pass");
    end else begin
      $display("disk_image_header_and_sector_locator regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dhsl_pkg.sv
rtl/core/dhsl_dp.sv
rtl/core/dhsl_ctrl.sv
rtl/core/disk_image_header_and_sector_locator.sv
tb/tb_top.sv
